>>> hw/rtl/bis_pkg.sv
`timescale 1ns / 1ps

package bis_pkg;

  localparam int PIX_W      = 8;
  localparam int PIX_FRAC   = 8;
  localparam int SMP_W      = 16;
  localparam int CNT_W      = 17;
  localparam int RC_W       = 8;
  localparam int POS_W      = 16;
  localparam int CFG_W      = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int LIM_W      = 13;

  localparam int IN_ROW_LSB  = 0;
  localparam int IN_COL_LSB  = IN_ROW_LSB + RC_W;
  localparam int IN_PIX_LSB  = IN_COL_LSB + RC_W;
  localparam int IN_SROW_LSB = IN_PIX_LSB + PIX_W;
  localparam int IN_SCOL_LSB = IN_SROW_LSB + POS_W;
  localparam int IN_DATA_W   = 56;
  localparam int IN_USER_W   = 1;
  localparam int OUT_DATA_W  = 40;

  localparam logic [PIX_W-1:0]     BRIGHT_LEVEL = 8'd128;
  localparam logic [CFG_W-1:0]     CFG_RESET    = 9'd256;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS     = 1'b1;
  localparam logic                 OP_WRITE     = 1'b0;
  localparam logic                 OP_SAMPLE    = 1'b1;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_WRITE  = 5'b00100,
    ST_SAMPLE = 5'b01000,
    ST_DONE   = 5'b10000
  } st_t;

endpackage

>>> hw/rtl/bilinear_image_sampler.sv
`timescale 1ns / 1ps

// Channel   Dir  Ports                         Contents
// in_       in   in_tvalid/in_tready           op in tuser; write and sample fields in tdata
// out_      out  out_tvalid/out_tready         sample_value, bright_count
// cfg_      in   cfg_we/cfg_index/cfg_wdata    rows_in_use (0), cols_in_use (1)
//
// Write item: accept with old-pixel read, write back, result load.
// Sample item: the four neighbor reads share the single image RAM port.
// After reset a clearing pass zeroes all MAX_ROWS*MAX_COLS RAM words
// (65536 by default), with in_tready low.
// A result waits in the output register; a new item is taken meanwhile, and
// only the final load stalls on out_tready.

module bilinear_image_sampler #(
  parameter int MAX_ROWS  = 256,
  parameter int MAX_COLS  = 256,
  parameter int FRAC_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // write_row, write_col, pixel_value, sample_row_pos, sample_col_pos
  input  logic [bis_pkg::IN_DATA_W-1:0]       in_tdata,
  // op
  input  logic [bis_pkg::IN_USER_W-1:0]       in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // sample_value, bright_count, zero pad
  output logic [bis_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  logic                                cfg_we,
  input  logic [bis_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bis_pkg::CFG_W-1:0]           cfg_wdata
);

  import bis_pkg::*;

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CO_W   = 17 - FRAC_BITS;
  localparam int W_W    = FRAC_BITS + 1;
  localparam int SUM_W  = SMP_W + W_W + 1;

  localparam logic [LIM_W-1:0]  ROW_MAX   = LIM_W'(MAX_ROWS);
  localparam logic [LIM_W-1:0]  COL_MAX   = LIM_W'(MAX_COLS);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);
  localparam logic [W_W-1:0]    W_ONE     = W_W'(1) << FRAC_BITS;

  st_t                   state_r, state_nxt;
  logic [1:0]            step_r;
  logic [ADDR_W-1:0]     clr_r;
  logic [CFG_W-1:0]      rows_r, cols_r;
  logic [CNT_W-1:0]      bright_r;
  logic [CO_W-1:0]       fr_r, fc_r;
  logic [FRAC_BITS-1:0]  alpha_r, beta_r;
  logic [3:0]            mask_r;
  logic                  is_smp_r;
  logic [ADDR_W-1:0]     wr_addr_r;
  logic [PIX_W-1:0]      wr_val_r;
  logic                  wr_ok_r;
  logic [SMP_W-1:0]      pix_a_r, top_r, bot_r;
  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  logic [PIX_W-1:0]      mem [DEPTH];
  logic [PIX_W-1:0]      rdata_r;
  logic [ADDR_W-1:0]     mem_addr;
  logic                  mem_we;
  logic [PIX_W-1:0]      mem_wdata;

  logic                  in_op;
  logic [RC_W-1:0]       in_row, in_col;
  logic [PIX_W-1:0]      in_pix;
  logic [POS_W-1:0]      in_srow, in_scol;
  logic [CO_W-1:0]       in_fr, in_fc, in_fr1, in_fc1;
  logic [LIM_W-1:0]      rlim, clim;
  logic                  in_r0_ok, in_r1_ok, in_c0_ok, in_c1_ok;
  logic [3:0]            in_mask;
  logic                  in_store;
  logic                  in_acc;
  logic                  out_free;
  logic [CO_W-1:0]       fr1, fc1, smp_r_idx, smp_c_idx;
  logic [SMP_W-1:0]      rd_pix;
  logic [SMP_W-1:0]      bl_a, bl_b, bl_out;
  logic [FRAC_BITS-1:0]  bl_w;
  logic [W_W-1:0]        bl_omw;
  logic [SUM_W-1:0]      bl_sum;
  logic [CNT_W-1:0]      bright_nxt;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [LIM_W-1:0] r,
                                               input logic [LIM_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c);
  endfunction

  assign in_op   = in_tuser[0];
  assign in_row  = in_tdata[IN_ROW_LSB +: RC_W];
  assign in_col  = in_tdata[IN_COL_LSB +: RC_W];
  assign in_pix  = in_tdata[IN_PIX_LSB +: PIX_W];
  assign in_srow = in_tdata[IN_SROW_LSB +: POS_W];
  assign in_scol = in_tdata[IN_SCOL_LSB +: POS_W];

  assign rlim = (LIM_W'(rows_r) < ROW_MAX) ? LIM_W'(rows_r) : ROW_MAX;
  assign clim = (LIM_W'(cols_r) < COL_MAX) ? LIM_W'(cols_r) : COL_MAX;

  assign in_fr  = CO_W'(in_srow >> FRAC_BITS);
  assign in_fc  = CO_W'(in_scol >> FRAC_BITS);
  assign in_fr1 = in_fr + CO_W'(1);
  assign in_fc1 = in_fc + CO_W'(1);

  assign in_r0_ok = LIM_W'(in_fr) < rlim;
  assign in_r1_ok = LIM_W'(in_fr1) < rlim;
  assign in_c0_ok = LIM_W'(in_fc) < clim;
  assign in_c1_ok = LIM_W'(in_fc1) < clim;
  assign in_mask  = {in_r1_ok && in_c1_ok, in_r1_ok && in_c0_ok,
                     in_r0_ok && in_c1_ok, in_r0_ok && in_c0_ok};

  assign in_store = (LIM_W'(in_row) < ROW_MAX) && (LIM_W'(in_col) < COL_MAX);

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;

  assign fr1       = fr_r + CO_W'(1);
  assign fc1       = fc_r + CO_W'(1);
  assign smp_r_idx = (step_r == 2'd0) ? fr_r : fr1;
  assign smp_c_idx = (step_r == 2'd1) ? fc_r : fc1;

  assign rd_pix = mask_r[step_r] ? {rdata_r, {PIX_FRAC{1'b0}}} : '0;

  assign bl_omw = W_ONE - W_W'(bl_w);
  assign bl_sum = SUM_W'(bl_a) * SUM_W'(bl_omw) + SUM_W'(bl_b) * SUM_W'(bl_w);
  assign bl_out = SMP_W'(bl_sum >> FRAC_BITS);

  always_comb begin
    bright_nxt = bright_r;
    if (wr_ok_r) begin
      bright_nxt = bright_r - CNT_W'(rdata_r >= BRIGHT_LEVEL)
                            + CNT_W'(wr_val_r >= BRIGHT_LEVEL);
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = clr_r;
    mem_wdata = '0;
    bl_a      = pix_a_r;
    bl_b      = rd_pix;
    bl_w      = alpha_r;
    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr_r == ADDR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        mem_addr  = (in_op == OP_SAMPLE) ? addr_of(LIM_W'(in_fr), LIM_W'(in_fc))
                                         : addr_of(LIM_W'(in_row), LIM_W'(in_col));
        if (in_tvalid) begin
          state_nxt = (in_op == OP_SAMPLE) ? ST_SAMPLE : ST_WRITE;
        end
      end
      ST_WRITE: begin
        mem_we    = wr_ok_r;
        mem_addr  = wr_addr_r;
        mem_wdata = wr_val_r;
        state_nxt = ST_DONE;
      end
      ST_SAMPLE: begin
        mem_addr = addr_of(LIM_W'(smp_r_idx), LIM_W'(smp_c_idx));
        if (step_r == 2'd3) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        bl_a = top_r;
        bl_b = bot_r;
        bl_w = beta_r;
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      step_r       <= 2'd0;
      clr_r        <= '0;
      rows_r       <= CFG_RESET;
      cols_r       <= CFG_RESET;
      bright_r     <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + ADDR_W'(1);
      end
      if (state_r == ST_SAMPLE) begin
        step_r <= step_r + 2'd1;
      end else begin
        step_r <= 2'd0;
      end
      if (state_r == ST_WRITE) begin
        bright_r <= bright_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_ROWS: rows_r <= cfg_wdata;
          CFG_COLS: cols_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (state_r == ST_DONE && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      is_smp_r  <= (in_op == OP_SAMPLE);
      fr_r      <= in_fr;
      fc_r      <= in_fc;
      alpha_r   <= in_scol[FRAC_BITS-1:0];
      beta_r    <= in_srow[FRAC_BITS-1:0];
      mask_r    <= in_mask;
      wr_addr_r <= addr_of(LIM_W'(in_row), LIM_W'(in_col));
      wr_val_r  <= in_pix;
      wr_ok_r   <= in_store && (in_op == OP_WRITE);
    end
    if (state_r == ST_SAMPLE) begin
      case (step_r)
        2'd0:    pix_a_r <= rd_pix;
        2'd1:    top_r   <= bl_out;
        2'd2:    pix_a_r <= rd_pix;
        2'd3:    bot_r   <= bl_out;
        default: pix_a_r <= rd_pix;
      endcase
    end
    if (state_r == ST_DONE && out_free) begin
      out_tdata_r <= OUT_DATA_W'({bright_r, is_smp_r ? bl_out : {SMP_W{1'b0}}});
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef SYNTH
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("item accepted while previous item in progress");

  a_mem_write: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_CLEAR || state_r == ST_WRITE))
    else $error("image RAM written outside clear or write");

  a_bright_src: assert property (@(posedge clk) disable iff (!rst_n)
    (bright_r != $past(bright_r)) |-> $past(state_r == ST_WRITE))
    else $error("bright count changed without a write item");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == ST_DONE))
    else $error("result loaded outside the done step");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !out_tvalid_r)
    else $error("result pending during clearing pass");
`endif

endmodule
